// ----- sv/ouid_pkg.sv -----
package ouid_pkg;

  // Default number of list entries.
  localparam int unsigned CAPACITY = 32;

  // Reset value of the size limit register.
  localparam logic [5:0] MAX_ENTRIES_RESET = 6'd32;

  // Request operation codes; the unused code behaves as a lookup.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_INVALID   = 3'd1,
    STATUS_CONFLICT  = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    IDLE,
    SEARCH,
    DECIDE,
    SHIFT,
    FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        key_valid;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [4:0]  match_index;
    logic [5:0]  entry_total;
  } out_item_t;

  // One stored identifier.
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } entry_t;

endpackage

// ----- sv/ouid_mem.sv -----
module ouid_mem #(
  parameter int unsigned Depth = ouid_pkg::CAPACITY,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  ouid_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output ouid_pkg::entry_t     rdata_o
);
  import ouid_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ouid_ctrl.sv -----
module ouid_ctrl #(
  parameter int unsigned Capacity = ouid_pkg::CAPACITY,
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [5:0]           max_entries_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ouid_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ouid_pkg::out_item_t  out_item_o,
  output logic                 mem_we_o,
  output logic [IdxW-1:0]      mem_waddr_o,
  output ouid_pkg::entry_t     mem_wdata_o,
  output logic                 mem_re_o,
  output logic [IdxW-1:0]      mem_raddr_o,
  input  ouid_pkg::entry_t     mem_rdata_i
);
  import ouid_pkg::*;

  state_e            state_q, state_d;
  in_item_t          key_q, key_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [CntW-1:0]   pidx_q, pidx_d;
  logic              hit_q, hit_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   src_q, src_d;
  logic [CntW-1:0]   lim_q, lim_d;
  logic [CntW-1:0]   wdst_q, wdst_d;
  logic              spend_q, spend_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              match;
  logic              cap_bad;
  logic              full;
  status_e           status;
  logic [CntW+5:0]   pos_wide;
  logic [CntW+5:0]   total_wide;

  // The word read in the previous cycle holds the searched key.
  assign match = pend_q && (mem_rdata_i.key_high == key_q.key_high)
                        && (mem_rdata_i.key_low == key_q.key_low);

  assign cap_bad  = 32'(max_entries_i) > Capacity;
  assign full     = 32'(count_q) >= 32'(max_entries_i);
  assign pos_wide = {6'd0, pos_q};

  // Next state, memory accesses and result assembly.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    src_d       = src_q;
    lim_d       = lim_q;
    wdst_d      = wdst_q;
    spend_d     = spend_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '{key_high: key_q.key_high, key_low: key_q.key_low};
    mem_re_o    = 1'b0;
    mem_raddr_o = scan_q[IdxW-1:0];
    status      = STATUS_OK;
    total_wide  = '0;

    case (state_q)
      IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          key_d  = in_item_i;
          scan_d = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          pos_d  = '0;
          state_d = (count_q != '0) ? SEARCH : DECIDE;
        end
      end

      // Scan live entries, one read issued and one compare per cycle.
      SEARCH: begin
        if (match) begin
          hit_d   = 1'b1;
          pos_d   = pidx_q;
          pend_d  = 1'b0;
          state_d = DECIDE;
        end else if (pend_q && (pidx_q + CntW'(1) == count_q)) begin
          pend_d  = 1'b0;
          state_d = DECIDE;
        end else if (scan_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_q[IdxW-1:0];
          scan_d      = scan_q + CntW'(1);
          pidx_d      = scan_q;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      // Apply the operation and record the result.
      DECIDE: begin
        state_d = FINISH;
        case (key_q.op)
          OP_APPEND: begin
            if (!key_q.key_valid || cap_bad) begin
              status = STATUS_INVALID;
            end else if (hit_q) begin
              status = STATUS_CONFLICT;
            end else if (full) begin
              status = STATUS_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[IdxW-1:0];
              count_d     = count_q + CntW'(1);
            end
          end
          OP_REMOVE: begin
            if (!hit_q) begin
              status = STATUS_NOT_FOUND;
            end else begin
              count_d = count_q - CntW'(1);
              src_d   = pos_q + CntW'(1);
              lim_d   = count_q;
              spend_d = 1'b0;
              if (pos_q + CntW'(1) < count_q) begin
                state_d = SHIFT;
              end
            end
          end
          default: begin
            status = STATUS_OK;
          end
        endcase
        total_wide = {6'd0, count_d};
        res_d.status      = status;
        res_d.found       = hit_q;
        res_d.match_index = pos_wide[4:0];
        res_d.entry_total = total_wide[5:0];
      end

      // Move each later entry down one place: read one, write the previous.
      SHIFT: begin
        if (spend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wdst_q[IdxW-1:0];
          mem_wdata_o = mem_rdata_i;
        end
        if (src_q < lim_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = src_q[IdxW-1:0];
          src_d       = src_q + CntW'(1);
          wdst_d      = src_q - CntW'(1);
          spend_d     = 1'b1;
        end else begin
          spend_d = 1'b0;
          state_d = FINISH;
        end
      end

      // Hand the result to the output register once it is free.
      FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = IDLE;
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      spend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      spend_q     <= spend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    scan_q <= scan_d;
    pidx_q <= pidx_d;
    hit_q  <= hit_d;
    pos_q  <= pos_d;
    src_q  <= src_d;
    lim_q  <= lim_d;
    wdst_q <= wdst_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- sv/ordered_unique_id_list_unit.sv -----
// Search: with n live entries, the scan stops at a match at position k or reads all n entries
// on a miss, and an empty list skips the scan; a remove that hits then moves the later entries
// down, none for the last entry.
// Throughput: one item at a time; the next item is taken in the cycle after the result registers,
// so the linear search through the single read port of the key RAM sets the rate.
// Reset: the live count clears and the size limit returns to 32; the stored
// keys are not cleared, since only live entries are ever read.
module ordered_unique_id_list_unit #(
  parameter int unsigned Capacity = ouid_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [5:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ouid_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ouid_pkg::out_item_t  out_item_o
);
  import ouid_pkg::*;

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic [5:0]      max_entries_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  // Size limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RESET;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_wdata_i;
    end
  end

  ouid_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_entries_i (max_entries_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  ouid_mem #(.Depth(Capacity)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- sv/ouid_checker.sv -----
module ouid_checker #(
  parameter int unsigned Capacity = ouid_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ouid_pkg::out_item_t  out_item_o
);
  import ouid_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in work");

  // A duplicate is only reported for a key that was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_CONFLICT) |-> out_item_o.found)
    else $error("conflict without a match");

  // A miss reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.match_index == 5'd0)
    else $error("miss with a nonzero position");

  // The live count never passes the list size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.entry_total) <= Capacity)
    else $error("entry count above capacity");

endmodule

bind ordered_unique_id_list_unit ouid_checker #(.Capacity(Capacity)) u_checker (.*);
